// ===== rtl/core/mfd_pkg.sv =====
// package for the modulated fractional delay block
// field widths, register indexes, default sizes and the controller command struct
// no dependencies
package mfd_pkg;

  localparam int LINE_DEPTH_DEF  = 32768;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int BASE_DELAY_W = 23;
  localparam int GAIN_W       = 16;
  localparam int MOD_W        = 16;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = BASE_DELAY_W;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_DELAY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_GAIN = 1'b1;

  localparam logic [BASE_DELAY_W-1:0] BASE_DELAY_RST = '0;
  localparam logic [GAIN_W-1:0]       DEPTH_GAIN_RST = 16'd8192;

  typedef struct packed {
    logic accept;  // latch request, write line store, start delay and gain products
    logic rd;      // form read addresses and read both taps
    logic interp;  // interpolate between the taps
    logic mix;     // scale delayed sample by gain
    logic load;    // add, saturate and load output register
  } mfd_cmd_t;

endpackage

// ===== rtl/core/mfd_ram.sv =====
// generic memory: one write port, two registered read ports
// no dependencies
module mfd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] ra_addr_i,
  input  logic [$clog2(DEPTH)-1:0] rb_addr_i,
  output logic [WIDTH-1:0]         ra_data_o,
  output logic [WIDTH-1:0]         rb_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] ra_data_q;
  logic [WIDTH-1:0] rb_data_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      ra_data_q <= mem_q[ra_addr_i];
      rb_data_q <= mem_q[rb_addr_i];
    end
  end

  assign ra_data_o = ra_data_q;
  assign rb_data_o = rb_data_q;

endmodule

// ===== rtl/core/mfd_ctrl.sv =====
// controller for the modulated fractional delay: sequences one request through
// address, interpolate, mix and output steps; owns the output valid flag
// depends on mfd_pkg
module mfd_ctrl
  import mfd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output mfd_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADDR,
    S_INTERP,
    S_MIX,
    S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   load;

  // output register is free when empty or being drained this cycle
  assign load = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_ADDR;
      S_ADDR:   state_d = S_INTERP;
      S_INTERP: state_d = S_MIX;
      S_MIX:    state_d = S_OUT;
      S_OUT:    if (load) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase

    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;

  assign cmd_o.accept = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.rd     = (state_q == S_ADDR);
  assign cmd_o.interp = (state_q == S_INTERP);
  assign cmd_o.mix    = (state_q == S_MIX);
  assign cmd_o.load   = load;

`ifndef NO_ASSERTIONS
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_ADDR))
    else $error("accepted request did not start the sequence");

  a_cmd_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.accept, cmd_o.rd, cmd_o.interp, cmd_o.mix, cmd_o.load}))
    else $error("more than one datapath command at once");

  a_valid_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_OUT))
    else $error("output valid rose outside the output step");
`endif

endmodule

// ===== rtl/core/mfd_datapath.sv =====
// datapath for the modulated fractional delay: config registers, line store,
// write pointer, delay and gain products, interpolation and saturating mix
// depends on mfd_pkg and mfd_ram
module mfd_datapath
  import mfd_pkg::*;
#(
  parameter int LINE_DEPTH  = LINE_DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic [SAMPLE_BITS-1:0] in_sample_i,
  input  logic [MOD_W-1:0]       delay_mod_i,
  input  logic [MOD_W-1:0]       depth_mod_i,
  input  mfd_cmd_t               cmd_i,
  output logic [SAMPLE_BITS-1:0] out_sample_o
);

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int SB = SAMPLE_BITS;
  localparam int DW = (AW + 8 > 24) ? AW + 8 : 24;
  localparam logic [DW-1:0] DMAX     = DW'((LINE_DEPTH - 2) * 256);
  localparam logic [AW-1:0] LAST_IDX = AW'(LINE_DEPTH - 1);
  localparam logic [AW-1:0] DEPTH_AW = AW'(LINE_DEPTH);

  // configuration
  logic [BASE_DELAY_W-1:0] base_delay_q;
  logic [GAIN_W-1:0]       depth_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_delay_q <= BASE_DELAY_RST;
      depth_gain_q <= DEPTH_GAIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_BASE_DELAY: base_delay_q <= cfg_wdata_i;
        REG_DEPTH_GAIN: depth_gain_q <= cfg_wdata_i[GAIN_W-1:0];
        default:        ;
      endcase
    end
  end

  // write pointer; entries past the pointer before the first wrap read as zero
  logic [AW-1:0] wr_idx_q;
  logic          wrapped_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q  <= '0;
      wrapped_q <= 1'b0;
    end else if (cmd_i.accept) begin
      if (wr_idx_q == LAST_IDX) begin
        wr_idx_q  <= '0;
        wrapped_q <= 1'b1;
      end else begin
        wr_idx_q <= wr_idx_q + 1'b1;
      end
    end
  end

  // accept step: latch sample, start both products
  logic [SB-1:0]                   x_q;
  logic [AW-1:0]                   newest_q;
  logic [BASE_DELAY_W+MOD_W-1:0]   dprod_q;
  logic signed [GAIN_W+MOD_W:0]    gprod_q;
  logic [MOD_W-1:0]                dscale;
  logic [MOD_W-1:0]                gscale;

  // 1 + mod in Q1.15 is the mod with its sign bit flipped, as unsigned
  assign dscale = {~delay_mod_i[MOD_W-1], delay_mod_i[MOD_W-2:0]};
  assign gscale = {~depth_mod_i[MOD_W-1], depth_mod_i[MOD_W-2:0]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      x_q      <= in_sample_i;
      newest_q <= wr_idx_q;
      dprod_q  <= base_delay_q * dscale;
      gprod_q  <= $signed(depth_gain_q) * $signed({1'b0, gscale});
    end
  end

  // address step: clamp delay and find both taps
  logic [DW-1:0] dly;
  logic [DW-1:0] dly_c;
  logic [AW-1:0] whole;
  logic [AW:0]   diff_idx;
  logic [AW-1:0] pa;
  logic [AW-1:0] pb;
  logic [7:0]    frac_q;
  logic          va_q;
  logic          vb_q;

  always_comb begin
    dly      = DW'(dprod_q[BASE_DELAY_W+MOD_W-1:15]);
    dly_c    = (dly > DMAX) ? DMAX : dly;
    whole    = dly_c[AW+7:8];
    diff_idx = {1'b0, newest_q} - {1'b0, whole};
    pa       = diff_idx[AW] ? diff_idx[AW-1:0] + DEPTH_AW : diff_idx[AW-1:0];
    pb       = (pa == '0) ? LAST_IDX : pa - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      frac_q <= dly_c[7:0];
      va_q   <= wrapped_q || (pa <= newest_q);
      vb_q   <= wrapped_q || (pb <= newest_q);
    end
  end

  logic [SB-1:0] ra_data;
  logic [SB-1:0] rb_data;

  mfd_ram #(
    .WIDTH (SB),
    .DEPTH (LINE_DEPTH)
  ) u_line (
    .clk_i     (clk_i),
    .we_i      (cmd_i.accept),
    .waddr_i   (wr_idx_q),
    .wdata_i   (in_sample_i),
    .re_i      (cmd_i.rd),
    .ra_addr_i (pa),
    .rb_addr_i (pb),
    .ra_data_o (ra_data),
    .rb_data_o (rb_data)
  );

  // interpolate step: larger fraction moves toward the older tap
  logic [SB-1:0]        tap_a;
  logic [SB-1:0]        tap_b;
  logic signed [SB:0]   tap_diff;
  logic signed [SB+9:0] iprod;
  logic [SB+1:0]        isum;
  logic [SB-1:0]        delayed_q;

  always_comb begin
    tap_a    = va_q ? ra_data : '0;
    tap_b    = vb_q ? rb_data : '0;
    tap_diff = $signed({tap_b[SB-1], tap_b}) - $signed({tap_a[SB-1], tap_a});
    iprod    = tap_diff * $signed({1'b0, frac_q});
    isum     = {{2{tap_a[SB-1]}}, tap_a} + iprod[SB+9:8];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.interp) begin
      delayed_q <= isum[SB-1:0];
    end
  end

  // mix step
  logic signed [17:0]    gain;
  logic signed [SB+17:0] mix_q;

  assign gain = $signed(gprod_q[GAIN_W+MOD_W:15]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mix) begin
      mix_q <= gain * $signed(delayed_q);
    end
  end

  // output step: add dry sample and saturate
  logic [SB+4:0] ysum;
  logic          ovf;
  logic [SB-1:0] ysat;
  logic [SB-1:0] out_q;

  always_comb begin
    ysum = {{5{x_q[SB-1]}}, x_q} + {mix_q[SB+17], mix_q[SB+17:14]};
    // out of range when the sample sign bit and the bits above it disagree
    ovf  = !((ysum[SB+4:SB-1] == '0) || (ysum[SB+4:SB-1] == '1));
    if (!ovf) begin
      ysat = ysum[SB-1:0];
    end else if (ysum[SB+4]) begin
      ysat = {1'b1, {(SB-1){1'b0}}};
    end else begin
      ysat = {1'b0, {(SB-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_q <= ysat;
    end
  end

  assign out_sample_o = out_q;

`ifndef NO_ASSERTIONS
  a_wr_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_idx_q <= LAST_IDX)
    else $error("write pointer beyond line depth");
`endif

endmodule

// ===== rtl/core/modulated_fractional_delay.sv =====
// Modulated fractional delay, one audio channel, feed-forward.
// Input channel: in_valid_i / in_stall_o with in_sample_i (Q1.15), delay_mod_i and
// depth_mod_i (Q1.15, zero when unused). Output channel: out_valid_o / out_stall_i
// with out_sample_o, the input plus the gain-scaled delayed sample, saturated.
// A request is taken when valid is high and stall is low; exactly one result follows.
// Config: cfg_we_i writes cfg_wdata_i to base_delay (index 0, Q15.8 samples) or
// depth_gain (index 1, Q2.14); write only while no request is in flight.
// out_valid_o is registered and rises once the output step loads the result. The
// controller takes no new request until it is through with the last: it steps through
// the accepting cycle, the address and tap read step, then the interpolate, mix and
// output steps. The next request is taken while a finished result still sits in the
// output register; if that register is still full and out_stall_i is high when a new
// result is ready, the controller waits in its output step and in_stall_o stays high.
// Reset: config returns to base_delay 0 and depth_gain 0.5, the write pointer to 0.
// The line store is not swept: entries not yet written since reset read as zero,
// tracked from the write pointer and a wrap flag, so the block is ready at once.
// depends on mfd_pkg, mfd_ctrl, mfd_datapath, mfd_ram
module modulated_fractional_delay
  import mfd_pkg::*;
#(
  parameter int LINE_DEPTH  = LINE_DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [SAMPLE_BITS-1:0] in_sample_i,
  input  logic [MOD_W-1:0]       delay_mod_i,
  input  logic [MOD_W-1:0]       depth_mod_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [SAMPLE_BITS-1:0] out_sample_o
);

  mfd_cmd_t cmd;

  mfd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  mfd_datapath #(
    .LINE_DEPTH  (LINE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_sample_i  (in_sample_i),
    .delay_mod_i  (delay_mod_i),
    .depth_mod_i  (depth_mod_i),
    .cmd_i        (cmd),
    .out_sample_o (out_sample_o)
  );

endmodule
